[design/assert_macros.svh]
// Assertion macros shared by the closest-approach design.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

[design/plca_pkg.sv]
// Shared widths, beat structs and register codes for the closest-approach block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package plca_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CW         = COORD_BITS;

  localparam int DIFF_W  = CW + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int DOT_W   = PROD_W + 2;
  localparam int DSQ_W   = PROD_W;
  localparam int CMAG_W  = PROD_W;
  localparam int SPLIT   = CW;
  localparam int HI_W    = CMAG_W - SPLIT;
  localparam int DMAG_W  = DIFF_W;
  localparam int DOTM_W  = DOT_W - 1;
  localparam int DHI_W   = DOTM_W - SPLIT;
  localparam int NUM_W   = DMAG_W + DOTM_W;
  localparam int C2_W    = 2 * CMAG_W;
  localparam int DIV_W   = C2_W;
  localparam int QW      = 2 * (CW - 1);
  localparam int SQ_W    = QW;
  localparam int RES_W   = QW + 2;

  localparam int DIV_STEPS    = QW;
  localparam int SQ_STEPS     = CW - 1;
  localparam int FRONT_STAGES = 7;
  localparam int TOTAL_STAGES = FRONT_STAGES + DIV_STEPS + 1 + SQ_STEPS;
  localparam int CNT_W        = $clog2(TOTAL_STAGES + 1);

  localparam int LANES     = 4;
  localparam int LANE_DIST = 0;
  localparam int CFG_IDX_W = 3;

  typedef logic [2:0][CW-1:0] coord_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_X, REG_A_Y, REG_A_Z, REG_B_X, REG_B_Y, REG_B_Z
  } cfg_reg_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QW-1:0]    quo;
  } div_lane_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
    logic       dist_sat;
  } div_side_t;

  typedef struct packed {
    div_lane_t [LANES-1:0] lane;
    div_side_t             side;
  } div_beat_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
    logic [SQ_W-1:0] bitv;
  } sq_work_t;

  typedef struct packed {
    coord_vec_t close;
    logic       close_sat;
    logic       deg;
    logic       dist_sat;
  } sq_side_t;

  typedef struct packed {
    sq_work_t work;
    sq_side_t side;
  } sq_beat_t;

endpackage

[design/plca_front.sv]
// Front pipeline: differences, cross and dot products, squared lengths and
// divider setup. Depends on plca_pkg.
`timescale 1ns / 1ps

module plca_front (
  input  logic                 clk,
  input  logic                 rst,
  input  plca_pkg::coord_vec_t line_a,
  input  plca_pkg::coord_vec_t line_b,
  input  plca_pkg::coord_vec_t point,
  input  logic                 up_valid,
  output logic                 up_ready,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output plca_pkg::div_beat_t  dn_beat
);
  import plca_pkg::*;

  localparam int LAST = FRONT_STAGES - 1;

  logic [FRONT_STAGES-1:0] v, rdy;

  always_comb begin
    rdy[LAST] = !v[LAST] | dn_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v[k] | rdy[k+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= up_valid;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: differences
  logic signed [DIFF_W-1:0] s1_d [3];
  logic signed [DIFF_W-1:0] s1_w [3];
  logic                     s1_deg;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_d[i] <= DIFF_W'($signed(line_b[i])) - DIFF_W'($signed(line_a[i]));
        s1_w[i] <= DIFF_W'($signed(line_a[i])) - DIFF_W'($signed(point[i]));
      end
      s1_deg <= (line_a == line_b);
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] s2_pa [3];
  logic signed [PROD_W-1:0] s2_pb [3];
  logic signed [PROD_W-1:0] s2_pw [3];
  logic signed [PROD_W-1:0] s2_pd [3];
  logic signed [DIFF_W-1:0] s2_d  [3];
  logic                     s2_deg;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_pa[0] <= s1_d[1] * s1_w[2];
      s2_pb[0] <= s1_d[2] * s1_w[1];
      s2_pa[1] <= s1_d[2] * s1_w[0];
      s2_pb[1] <= s1_d[0] * s1_w[2];
      s2_pa[2] <= s1_d[0] * s1_w[1];
      s2_pb[2] <= s1_d[1] * s1_w[0];
      for (int i = 0; i < 3; i++) begin
        s2_pw[i] <= s1_w[i] * s1_d[i];
        s2_pd[i] <= s1_d[i] * s1_d[i];
        s2_d[i]  <= s1_d[i];
      end
      s2_deg <= s1_deg;
    end
  end

  // stage 3: cross vector, dot, squared length
  logic signed [CROSS_W-1:0] s3_c [3];
  logic signed [DOT_W-1:0]   s3_dot;
  logic [DSQ_W-1:0]          s3_dsq;
  logic signed [DIFF_W-1:0]  s3_d [3];
  logic                      s3_deg;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_c[i] <= CROSS_W'(s2_pa[i]) - CROSS_W'(s2_pb[i]);
        s3_d[i] <= s2_d[i];
      end
      s3_dot <= -(DOT_W'(s2_pw[0]) + DOT_W'(s2_pw[1]) + DOT_W'(s2_pw[2]));
      s3_dsq <= $unsigned(s2_pd[0]) + $unsigned(s2_pd[1]) + $unsigned(s2_pd[2]);
      s3_deg <= s2_deg;
    end
  end

  // stage 4: partial products of squares and numerators
  logic [CMAG_W-1:0] cmag [3];
  logic [DMAG_W-1:0] dmag [3];
  logic [DOTM_W-1:0] dotmag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmag[i] = s3_c[i][CROSS_W-1] ? CMAG_W'(-s3_c[i]) : CMAG_W'(s3_c[i]);
      dmag[i] = s3_d[i][DIFF_W-1] ? DMAG_W'(-s3_d[i]) : DMAG_W'(s3_d[i]);
    end
    dotmag = s3_dot[DOT_W-1] ? DOTM_W'(-s3_dot) : DOTM_W'(s3_dot);
  end

  logic [2*SPLIT-1:0]       s4_ll [3];
  logic [SPLIT+HI_W-1:0]    s4_lh [3];
  logic [2*HI_W-1:0]        s4_hh [3];
  logic [DMAG_W+SPLIT-1:0]  s4_nl [3];
  logic [DMAG_W+DHI_W-1:0]  s4_nh [3];
  logic [2:0]               s4_neg;
  logic [DSQ_W-1:0]         s4_dsq;
  logic                     s4_deg;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_ll[i]  <= cmag[i][SPLIT-1:0] * cmag[i][SPLIT-1:0];
        s4_lh[i]  <= cmag[i][SPLIT-1:0] * cmag[i][CMAG_W-1:SPLIT];
        s4_hh[i]  <= cmag[i][CMAG_W-1:SPLIT] * cmag[i][CMAG_W-1:SPLIT];
        s4_nl[i]  <= dmag[i] * dotmag[SPLIT-1:0];
        s4_nh[i]  <= dmag[i] * dotmag[DOTM_W-1:SPLIT];
        s4_neg[i] <= s3_d[i][DIFF_W-1] ^ s3_dot[DOT_W-1];
      end
      s4_dsq <= s3_dsq;
      s4_deg <= s3_deg;
    end
  end

  // stage 5: assemble squares and numerators
  logic [C2_W-1:0]  s5_sq  [3];
  logic [NUM_W-1:0] s5_num [3];
  logic [2:0]       s5_neg;
  logic [DSQ_W-1:0] s5_dsq;
  logic             s5_deg;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq[i]  <= (C2_W'(s4_hh[i]) << (2 * SPLIT)) + (C2_W'(s4_lh[i]) << (SPLIT + 1))
                     + C2_W'(s4_ll[i]);
        s5_num[i] <= (NUM_W'(s4_nh[i]) << SPLIT) + NUM_W'(s4_nl[i]);
      end
      s5_neg <= s4_neg;
      s5_dsq <= s4_dsq;
      s5_deg <= s4_deg;
    end
  end

  // stage 6: cross length squared, rounded numerators
  logic [C2_W-1:0]  s6_c2;
  logic [DIV_W-1:0] s6_n [3];
  logic [2:0]       s6_neg;
  logic [DSQ_W-1:0] s6_dsq;
  logic             s6_deg;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_c2 <= s5_sq[0] + s5_sq[1] + s5_sq[2];
      for (int i = 0; i < 3; i++) begin
        s6_n[i] <= (DIV_W'(s5_num[i]) << 1) + DIV_W'(s5_dsq);
      end
      s6_neg <= s5_neg;
      s6_dsq <= s5_dsq;
      s6_deg <= s5_deg;
    end
  end

  // stage 7: divider setup
  logic [DIV_W-1:0] dvs_top;
  assign dvs_top = DIV_W'(s6_dsq) << QW;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      dn_beat.lane[LANE_DIST].rem <= s6_c2;
      dn_beat.lane[LANE_DIST].dvs <= DIV_W'(s6_dsq) << (QW - 1);
      dn_beat.lane[LANE_DIST].quo <= '0;
      for (int i = 0; i < 3; i++) begin
        dn_beat.lane[1+i].rem <= s6_n[i];
        dn_beat.lane[1+i].dvs <= dvs_top;
        dn_beat.lane[1+i].quo <= '0;
      end
      dn_beat.side.neg      <= s6_neg;
      dn_beat.side.deg      <= s6_deg;
      dn_beat.side.dist_sat <= (s6_c2 >= dvs_top);
    end
  end

endmodule

[design/plca_div_cell.sv]
// One restoring division step on four lanes; one quotient bit per lane per beat.
// Depends on plca_pkg.
`timescale 1ns / 1ps

module plca_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  plca_pkg::div_beat_t up_beat,
  output logic                dn_valid,
  input  logic                dn_ready,
  output plca_pkg::div_beat_t dn_beat
);
  import plca_pkg::*;

  div_beat_t nxt;
  logic      v;

  always_comb begin
    nxt = up_beat;
    for (int l = 0; l < LANES; l++) begin
      if (up_beat.lane[l].rem >= up_beat.lane[l].dvs) begin
        nxt.lane[l].rem = up_beat.lane[l].rem - up_beat.lane[l].dvs;
        nxt.lane[l].quo = {up_beat.lane[l].quo[QW-2:0], 1'b1};
      end else begin
        nxt.lane[l].quo = {up_beat.lane[l].quo[QW-2:0], 1'b0};
      end
      nxt.lane[l].dvs = up_beat.lane[l].dvs >> 1;
    end
  end

  assign up_ready = !v | dn_ready;
  assign dn_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) dn_beat <= nxt;
  end

endmodule

[design/plca_sqrt_cell.sv]
// One digit-by-digit integer square root step; one root bit per beat.
// Depends on plca_pkg.
`timescale 1ns / 1ps

module plca_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  plca_pkg::sq_beat_t up_beat,
  output logic               dn_valid,
  input  logic               dn_ready,
  output plca_pkg::sq_beat_t dn_beat
);
  import plca_pkg::*;

  sq_beat_t        nxt;
  logic [SQ_W-1:0] trial;
  logic            v;

  always_comb begin
    nxt   = up_beat;
    trial = up_beat.work.root + up_beat.work.bitv;
    if (up_beat.work.rem >= trial) begin
      nxt.work.rem  = up_beat.work.rem - trial;
      nxt.work.root = (up_beat.work.root >> 1) + up_beat.work.bitv;
    end else begin
      nxt.work.root = up_beat.work.root >> 1;
    end
    nxt.work.bitv = up_beat.work.bitv >> 2;
  end

  assign up_ready = !v | dn_ready;
  assign dn_valid = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) dn_beat <= nxt;
  end

endmodule

[design/point_line_closest_approach.sv]
// Point to line closest approach, 3D, signed Q15.16.
// Channels: point (point_valid/point_ready, point_x/y/z) in; result
// (result_valid/result_ready, distance, closest_x/y/z, degenerate_line,
// saturated) out; cfg (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// line points A (index 0..2) and B (index 3..5); other indexes are ignored.
// cfg_ready is always high; write only while no beat is in flight.
// Throughput: one beat per cycle while result_ready is high. A point passes
// through 7 front stages, a row of 62 division cells (one quotient bit each,
// four lanes), one rounding stage and a row of 31 square root cells.
// Every cell is a register slice with its own valid; a stalled result holds
// while upstream cells keep filling, so point_ready drops only once all 101
// slices are occupied.
// Reset: clears all slice valids; A = (0,0,0), B = (0,0,1.0).
// A degenerate line (A equal B) gives zeros with degenerate_line set.
// Depends on plca_pkg, plca_front, plca_div_cell, plca_sqrt_cell,
// assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_line_closest_approach (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            point_valid,
  output logic                            point_ready,
  input  logic signed [plca_pkg::CW-1:0]  point_x,
  input  logic signed [plca_pkg::CW-1:0]  point_y,
  input  logic signed [plca_pkg::CW-1:0]  point_z,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [plca_pkg::CW-2:0]         distance,
  output logic signed [plca_pkg::CW-1:0]  closest_x,
  output logic signed [plca_pkg::CW-1:0]  closest_y,
  output logic signed [plca_pkg::CW-1:0]  closest_z,
  output logic                            degenerate_line,
  output logic                            saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [plca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plca_pkg::CW-1:0]         cfg_data
);
  import plca_pkg::*;

  // configuration
  coord_vec_t line_a, line_b, pvec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_a <= '0;
      line_b <= {CW'(1) << FRAC_BITS, CW'(0), CW'(0)};
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_A_X: line_a[0] <= cfg_data;
        REG_A_Y: line_a[1] <= cfg_data;
        REG_A_Z: line_a[2] <= cfg_data;
        REG_B_X: line_b[0] <= cfg_data;
        REG_B_Y: line_b[1] <= cfg_data;
        REG_B_Z: line_b[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pvec[0] = point_x;
  assign pvec[1] = point_y;
  assign pvec[2] = point_z;

  // front and divider row
  logic [DIV_STEPS:0] div_v, div_r;
  div_beat_t          div_b [DIV_STEPS+1];

  plca_front u_front (
    .clk      (clk),
    .rst      (rst),
    .line_a   (line_a),
    .line_b   (line_b),
    .point    (pvec),
    .up_valid (point_valid),
    .up_ready (point_ready),
    .dn_valid (div_v[0]),
    .dn_ready (div_r[0]),
    .dn_beat  (div_b[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    plca_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_v[g]),
      .up_ready (div_r[g]),
      .up_beat  (div_b[g]),
      .dn_valid (div_v[g+1]),
      .dn_ready (div_r[g+1]),
      .dn_beat  (div_b[g+1])
    );
  end

  // rounding stage: closest point add and clip, root setup
  logic [SQ_STEPS:0] sq_v, sq_r;
  sq_beat_t          sq_b [SQ_STEPS+1];
  sq_beat_t          rnd_next;
  logic              rnd_v;

  always_comb begin
    logic signed [RES_W-1:0] av;
    logic signed [RES_W-1:0] qv;
    logic signed [RES_W-1:0] res;
    div_beat_t               db;
    db       = div_b[DIV_STEPS];
    rnd_next = '0;
    for (int i = 0; i < 3; i++) begin
      av  = RES_W'($signed(line_a[i]));
      qv  = $signed(RES_W'(db.lane[1+i].quo));
      res = db.side.neg[i] ? av - qv : av + qv;
      if (db.side.deg) begin
        rnd_next.side.close[i] = '0;
      end else if (res[RES_W-1:CW-1] == '0 || res[RES_W-1:CW-1] == '1) begin
        rnd_next.side.close[i] = res[CW-1:0];
      end else begin
        rnd_next.side.close[i] = {res[RES_W-1], {(CW-1){!res[RES_W-1]}}};
        rnd_next.side.close_sat = 1'b1;
      end
    end
    rnd_next.side.deg      = db.side.deg;
    rnd_next.side.dist_sat = db.side.dist_sat;
    rnd_next.work.rem      = db.lane[LANE_DIST].quo;
    rnd_next.work.root     = '0;
    rnd_next.work.bitv     = SQ_W'(1) << (SQ_W - 2);
  end

  assign div_r[DIV_STEPS] = !rnd_v | sq_r[0];
  assign sq_v[0]          = rnd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_v <= 1'b0;
    end else if (div_r[DIV_STEPS]) begin
      rnd_v <= div_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (div_r[DIV_STEPS]) sq_b[0] <= rnd_next;
  end

  // square root row
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    plca_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (sq_v[g]),
      .up_ready (sq_r[g]),
      .up_beat  (sq_b[g]),
      .dn_valid (sq_v[g+1]),
      .dn_ready (sq_r[g+1]),
      .dn_beat  (sq_b[g+1])
    );
  end

  // result
  sq_beat_t fin;
  assign fin          = sq_b[SQ_STEPS];
  assign sq_r[SQ_STEPS] = result_ready;
  assign result_valid = sq_v[SQ_STEPS];

  always_comb begin
    if (fin.side.deg) begin
      distance = '0;
    end else if (fin.side.dist_sat) begin
      distance = '1;
    end else begin
      distance = fin.work.root[CW-2:0];
    end
  end

  assign closest_x       = fin.side.close[0];
  assign closest_y       = fin.side.close[1];
  assign closest_z       = fin.side.close[2];
  assign degenerate_line = fin.side.deg;
  assign saturated       = !fin.side.deg & (fin.side.close_sat | fin.side.dist_sat);

  // beats in flight
  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({point_valid & point_ready, result_valid & result_ready})
        2'b10:   inflight <= inflight + CNT_W'(1);
        2'b01:   inflight <= inflight - CNT_W'(1);
        default: ;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_phantom, clk, rst, result_valid, inflight != '0)
  `ASSERT_ALWAYS(a_depth, clk, rst, inflight <= CNT_W'(TOTAL_STAGES))
  `ASSERT_IMPLIES(a_full_stall, clk, rst, !point_ready, result_valid && !result_ready)
  `ASSERT_IMPLIES(a_degen_zero, clk, rst, result_valid && degenerate_line, distance == '0 && !saturated && closest_x == '0)

endmodule

[verif/tb_top.sv]
// Self-checking bench for point_line_closest_approach: random and directed query points
// against a wide-integer predictor of distance and nearest point. Depends on plca_pkg.
`timescale 1ns / 1ps

module tb_top;
  import plca_pkg::*;

  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX = 3'd7;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic [30:0] DIST_MAX = '1;

  typedef struct {
    logic [30:0] dist_val;
    logic signed [31:0] cx, cy, cz;
    logic deg, sat;
  } approach_t;

  logic clk = 0, rst = 1;
  logic point_valid = 0, point_ready;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic result_valid, result_ready = 0;
  logic [30:0] distance;
  logic signed [31:0] closest_x, closest_y, closest_z;
  logic degenerate_line, saturated;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] line_a [3];
  logic signed [31:0] line_b [3];
  approach_t pending_q [$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;

  point_line_closest_approach dut (.*);

  always #5 clk = ~clk;

  function automatic approach_t predict_approach(logic signed [31:0] px, logic signed [31:0] py,
                                                 logic signed [31:0] pz);
    logic signed [191:0] a [3];
    logic signed [191:0] d [3];
    logic signed [191:0] w [3];
    logic signed [191:0] c [3];
    logic signed [191:0] dot, d2, c2, num, mag, qv, res, quo, root, trial;
    approach_t r;
    r = '{default: '0};
    if (line_a[0] == line_b[0] && line_a[1] == line_b[1] && line_a[2] == line_b[2]) begin
      r.deg = 1;
      return r;
    end
    dot = 0; d2 = 0; c2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = line_a[i];
      d[i] = a[i] - line_b[i];
      d[i] = -d[i];
      w[i] = a[i];
      w[i] = w[i] - (i == 0 ? px : i == 1 ? py : pz);
      d2 = d2 + d[i] * d[i];
      dot = dot - w[i] * d[i];
    end
    c[0] = d[1] * w[2] - d[2] * w[1];
    c[1] = d[2] * w[0] - d[0] * w[2];
    c[2] = d[0] * w[1] - d[1] * w[0];
    for (int i = 0; i < 3; i++) c2 = c2 + c[i] * c[i];
    quo = c2 / d2;
    root = 0;
    for (int k = 79; k >= 0; k--) begin
      trial = root | (192'sd1 <<< k);
      if (trial * trial <= quo) root = trial;
    end
    if (root > 64'sd2147483647) begin
      r.sat = 1;
      r.dist_val = DIST_MAX;
    end else begin
      r.dist_val = root[30:0];
    end
    for (int i = 0; i < 3; i++) begin
      num = d[i] * dot;
      mag = num < 0 ? -num : num;
      qv = (2 * mag + d2) / (2 * d2);
      if (num < 0) qv = -qv;
      res = a[i] + qv;
      if (res > 64'sd2147483647) begin
        r.sat = 1;
        res = 64'sd2147483647;
      end else if (res < -64'sd2147483648) begin
        r.sat = 1;
        res = -64'sd2147483648;
      end
      if (i == 0) r.cx = res[31:0];
      else if (i == 1) r.cy = res[31:0];
      else r.cz = res[31:0];
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    approach_t e;
    if (!rst && result_valid && result_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat dist=%h", $time, distance);
      end else begin
        e = pending_q.pop_front();
        if (distance !== e.dist_val) begin
          errors++;
          $display("%0t: distance exp %h got %h", $time, e.dist_val, distance);
        end
        if (closest_x !== e.cx) begin
          errors++;
          $display("%0t: closest_x exp %h got %h", $time, e.cx, closest_x);
        end
        if (closest_y !== e.cy) begin
          errors++;
          $display("%0t: closest_y exp %h got %h", $time, e.cy, closest_y);
        end
        if (closest_z !== e.cz) begin
          errors++;
          $display("%0t: closest_z exp %h got %h", $time, e.cz, closest_z);
        end
        if (degenerate_line !== e.deg) begin
          errors++;
          $display("%0t: degenerate_line exp %b got %b", $time, e.deg, degenerate_line);
        end
        if (saturated !== e.sat) begin
          errors++;
          $display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      result_ready <= 1;
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
                            bit gaps = 1);
    if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
      point_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    point_valid <= 1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (!point_ready);
    pending_q.push_back(predict_approach(x, y, z));
  endtask

  task automatic wait_drained();
    point_valid <= 0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_A_Z) line_a[idx] = val;
    else if (idx <= REG_B_Z) line_b[idx - REG_B_X] = val;
  endtask

  task automatic set_line(logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
                          logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
    wait_drained();
    write_reg(REG_A_X, ax);
    write_reg(REG_A_Y, ay);
    write_reg(REG_A_Z, az);
    write_reg(REG_B_X, bx);
    write_reg(REG_B_Y, by);
    write_reg(REG_B_Z, bz);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 1) ? CMAX - $urandom_range(0, 3) : CMIN + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_line();
    send_point(0, 0, 0);
    send_point(32'sh00010000, 32'sh00020000, 32'sh00030000);
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMIN, 0);
    send_point(-1, -1, -1);
  endtask

  task automatic test_unused_index();
    wait_drained();
    write_reg(UNUSED_IDX, 32'h12345678);
    cfg_valid <= 0;
    @(posedge clk);
    send_point(32'sh00050000, 0, 32'sh00010000);
  endtask

  task automatic test_field_extremes();
    set_line(CMIN, CMAX, 0, CMAX, CMIN, 32'sh00010000);
    send_point(CMIN, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
    send_point(0, CMAX, CMIN);
    send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
  endtask

  task automatic test_degenerate();
    set_line(32'sh00030000, -32'sh00020000, 7, 32'sh00030000, -32'sh00020000, 7);
    send_point(0, 0, 0);
    send_point(CMAX, CMIN, CMAX);
    set_line(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_point(1, 2, 3);
  endtask

  task automatic test_saturation();
    set_line(CMIN, CMIN, CMIN, CMIN + 1, CMIN, CMIN);
    send_point(CMAX, CMAX, CMAX);
    set_line(CMAX, CMIN, 0, CMAX - 1, CMIN + 1, 0);
    send_point(CMIN, CMAX, 0);
    send_point(CMAX, CMIN, 0);
    set_line(0, 0, 0, 1, 0, 0);
    send_point(123, CMAX, CMIN);
  endtask

  task automatic random_points(int n);
    logic signed [31:0] x, y, z;
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        x = $urandom; y = $urandom; z = $urandom;
      end else begin
        x = line_a[0] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        y = line_a[1] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        z = line_a[2] + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      end
      send_point(x, y, z);
    end
  endtask

  task automatic test_random_lines();
    logic signed [31:0] ax, ay, az;
    repeat (12) begin
      ax = rnd_coord(); ay = rnd_coord(); az = rnd_coord();
      case ($urandom_range(0, 5))
        0: set_line(ax, ay, az, ax, ay, az);
        1: set_line(ax, ay, az, ax + $urandom_range(1, 4), ay, az);
        default: set_line(ax, ay, az, rnd_coord(), rnd_coord(), rnd_coord());
      endcase
      random_points(60);
    end
  endtask

  task automatic test_backpressure();
    set_line(32'sh00010000, 0, -32'sh00010000, 0, 32'sh00040000, 32'sh00020000);
    hold_req = 1;
    repeat (200) send_point($urandom, $urandom, $urandom, 0);
  endtask

  task automatic test_steady_stream();
    wait_drained();
    quiet = 1;
    random_points(150);
  endtask

  initial begin
    line_a = '{0, 0, 0};
    line_b = '{0, 0, 32'sh00010000};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_line();
    test_unused_index();
    test_field_extremes();
    test_degenerate();
    test_saturation();
    test_random_lines();
    test_backpressure();
    test_steady_stream();
    wait_drained();
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
